FILE: rtl/cfn_pkg.sv
package cfn_pkg;

    localparam int CP_BITS     = 21;
    localparam int TOTAL_BITS  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int LETTER_BITS = 7;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    localparam logic [CP_BITS-1:0] SPACE_CP = 21'h00020;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result slots of one transaction, in the order they leave the block.
    localparam int SLOT_COUNT   = 3;
    localparam int SLOT_SPACE   = 0;
    localparam int SLOT_CHAR    = 1;
    localparam int SLOT_SUMMARY = 2;

    typedef struct packed {
        logic                   is_bidi;
        logic                   is_ws;
        logic                   is_mod;
        logic [LETTER_BITS-1:0] letter;
    } t_class;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] pend;
        logic [CP_BITS-1:0]    ch;
        logic [COUNT_BITS-1:0] rep;
        logic [COUNT_BITS-1:0] bid;
    } t_result_set;

    typedef struct packed {
        logic                   hit;
        logic [LETTER_BITS-1:0] letter;
    } t_mod_hit;

    function automatic logic is_bidi_cp(input logic [CP_BITS-1:0] cp);
        return cp inside {[21'h0202A:21'h0202E], [21'h02066:21'h02069],
                          21'h0200E, 21'h0200F};
    endfunction

    function automatic logic is_ws_cp(input logic [CP_BITS-1:0] cp);
        return cp inside {[21'h00009:21'h0000D], 21'h00020, 21'h01680,
                          [21'h02000:21'h02006], [21'h02008:21'h0200A],
                          21'h02028, 21'h02029, 21'h0205F, 21'h03000};
    endfunction

    function automatic t_mod_hit mod_lookup(input logic [CP_BITS-1:0] cp);
        t_mod_hit r;
        r.hit    = 1'b1;
        r.letter = '0;
        case (cp)
            21'h002E2: r.letter = 7'h73;
            21'h002B7: r.letter = 7'h77;
            21'h002E3: r.letter = 7'h78;
            21'h01D43: r.letter = 7'h61;
            21'h01D47: r.letter = 7'h62;
            21'h01D9C: r.letter = 7'h63;
            21'h01D48: r.letter = 7'h64;
            21'h01D49: r.letter = 7'h65;
            21'h01DA0: r.letter = 7'h66;
            21'h01D4D: r.letter = 7'h67;
            21'h002B0: r.letter = 7'h68;
            21'h01DA6: r.letter = 7'h69;
            21'h002B2: r.letter = 7'h6A;
            21'h01D4F: r.letter = 7'h6B;
            21'h002E1: r.letter = 7'h6C;
            21'h01D50: r.letter = 7'h6D;
            21'h01DB0: r.letter = 7'h6E;
            21'h01D52: r.letter = 7'h6F;
            21'h01D56: r.letter = 7'h70;
            21'h002B3: r.letter = 7'h72;
            21'h01D57: r.letter = 7'h74;
            21'h01D58: r.letter = 7'h75;
            21'h01D5B: r.letter = 7'h76;
            21'h002B8: r.letter = 7'h79;
            21'h01DBB: r.letter = 7'h7A;
            21'h01D2C: r.letter = 7'h41;
            21'h01D2E: r.letter = 7'h42;
            21'h01D30: r.letter = 7'h44;
            21'h01D31: r.letter = 7'h45;
            21'h01D33: r.letter = 7'h47;
            21'h01D34: r.letter = 7'h48;
            21'h01D35: r.letter = 7'h49;
            21'h01D36: r.letter = 7'h4A;
            21'h01D37: r.letter = 7'h4B;
            21'h01D38: r.letter = 7'h4C;
            21'h01D39: r.letter = 7'h4D;
            21'h01D3A: r.letter = 7'h4E;
            21'h01D3C: r.letter = 7'h4F;
            21'h01D3E: r.letter = 7'h50;
            21'h01D3F: r.letter = 7'h52;
            21'h01D40: r.letter = 7'h54;
            21'h01D41: r.letter = 7'h55;
            21'h02C7D: r.letter = 7'h56;
            21'h01D42: r.letter = 7'h57;
            21'h01D00: r.letter = 7'h41;
            21'h00299: r.letter = 7'h42;
            21'h01D04: r.letter = 7'h43;
            21'h01D05: r.letter = 7'h44;
            21'h01D07: r.letter = 7'h45;
            21'h00493: r.letter = 7'h46;
            21'h00262: r.letter = 7'h47;
            21'h0029C: r.letter = 7'h48;
            21'h0026A: r.letter = 7'h49;
            21'h01D0A: r.letter = 7'h4A;
            21'h01D0B: r.letter = 7'h4B;
            21'h0029F: r.letter = 7'h4C;
            21'h01D0D: r.letter = 7'h4D;
            21'h00274: r.letter = 7'h4E;
            21'h01D0F: r.letter = 7'h4F;
            21'h01D18: r.letter = 7'h50;
            21'h00280: r.letter = 7'h52;
            21'h01D1B: r.letter = 7'h54;
            21'h01D1C: r.letter = 7'h55;
            21'h01D20: r.letter = 7'h56;
            21'h01D21: r.letter = 7'h57;
            21'h0028F: r.letter = 7'h59;
            21'h01D22: r.letter = 7'h5A;
            default:   r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/cfn_classify.sv
module cfn_classify
    import cfn_pkg::*;
(
    input  logic [CP_BITS-1:0] i_code_point,
    output t_class             o_class
);

    t_mod_hit mod_hit;

    always_comb begin
        mod_hit          = mod_lookup(i_code_point);
        o_class.is_bidi  = is_bidi_cp(i_code_point);
        o_class.is_ws    = is_ws_cp(i_code_point);
        o_class.is_mod   = mod_hit.hit;
        o_class.letter   = mod_hit.letter;
    end

endmodule

FILE: rtl/cfn_track.sv
module cfn_track
    import cfn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_class             i_class,
    input  logic [CP_BITS-1:0] i_code_point,
    input  logic               i_has_char,
    input  logic               i_end_of_text,
    output t_result_set        o_set
);

    logic                  r_space_pending;
    logic                  r_emitted_any;
    logic [COUNT_BITS-1:0] r_rep_cnt;
    logic [COUNT_BITS-1:0] r_bid_cnt;

    logic                  n_space_pending;
    logic                  n_emitted_any;
    logic [COUNT_BITS-1:0] n_rep_cnt;
    logic [COUNT_BITS-1:0] n_bid_cnt;

    logic visible;
    logic bidi_hit;
    logic ws_hit;
    logic mod_hit;

    always_comb begin
        bidi_hit = i_has_char && i_class.is_bidi;
        ws_hit   = i_has_char && !i_class.is_bidi && i_class.is_ws;
        visible  = i_has_char && !i_class.is_bidi && !i_class.is_ws;
        mod_hit  = visible && i_class.is_mod;

        n_rep_cnt = r_rep_cnt;
        if (mod_hit && (r_rep_cnt != COUNT_MAX)) begin
            n_rep_cnt = r_rep_cnt + COUNT_ONE;
        end
        n_bid_cnt = r_bid_cnt;
        if (bidi_hit && (r_bid_cnt != COUNT_MAX)) begin
            n_bid_cnt = r_bid_cnt + COUNT_ONE;
        end

        n_space_pending = r_space_pending;
        if (visible) begin
            n_space_pending = 1'b0;
        end else if (ws_hit) begin
            n_space_pending = 1'b1;
        end
        n_emitted_any = r_emitted_any || visible;

        o_set.pend[SLOT_SPACE]   = visible && r_space_pending && r_emitted_any;
        o_set.pend[SLOT_CHAR]    = visible;
        o_set.pend[SLOT_SUMMARY] = i_end_of_text;
        o_set.ch  = i_class.is_mod ? CP_BITS'(i_class.letter) : i_code_point;
        o_set.rep = n_rep_cnt;
        o_set.bid = n_bid_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_pending <= 1'b0;
            r_emitted_any   <= 1'b0;
            r_rep_cnt       <= '0;
            r_bid_cnt       <= '0;
        end else if (i_advance) begin
            if (i_end_of_text) begin
                r_space_pending <= 1'b0;
                r_emitted_any   <= 1'b0;
                r_rep_cnt       <= '0;
                r_bid_cnt       <= '0;
            end else begin
                r_space_pending <= n_space_pending;
                r_emitted_any   <= n_emitted_any;
                r_rep_cnt       <= n_rep_cnt;
                r_bid_cnt       <= n_bid_cnt;
            end
        end
    end

endmodule

FILE: rtl/cfn_out_buffer.sv
module cfn_out_buffer
    import cfn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_result_set           i_set,
    output logic                  o_can_load,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_item_kind,
    output logic [CP_BITS-1:0]    o_out_char,
    output logic [TOTAL_BITS-1:0] o_replace_total,
    output logic [TOTAL_BITS-1:0] o_bidi_total,
    output logic                  o_last_of_run
);

    logic [SLOT_COUNT-1:0] r_pend;
    logic [CP_BITS-1:0]    r_char;
    logic [COUNT_BITS-1:0] r_rep;
    logic [COUNT_BITS-1:0] r_bid;

    logic [SLOT_COUNT-1:0] head;
    logic                  pop;

    always_comb begin
        head        = r_pend & (~r_pend + SLOT_COUNT'(1));
        o_out_valid = (r_pend != '0);
        pop         = o_out_valid && i_out_ready;
        o_can_load  = !o_out_valid || ($onehot(r_pend) && i_out_ready);

        o_last_of_run   = $onehot(r_pend);
        o_item_kind     = head[SLOT_SUMMARY] ? KIND_SUMMARY : KIND_CHAR;
        o_out_char      = '0;
        o_replace_total = '0;
        o_bidi_total    = '0;
        if (head[SLOT_SPACE]) begin
            o_out_char = SPACE_CP;
        end else if (head[SLOT_CHAR]) begin
            o_out_char = r_char;
        end else if (head[SLOT_SUMMARY]) begin
            o_replace_total = TOTAL_BITS'(r_rep);
            o_bidi_total    = TOTAL_BITS'(r_bid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= i_set.pend;
        end else if (pop) begin
            r_pend <= r_pend & (r_pend - SLOT_COUNT'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_set.ch;
            r_rep  <= i_set.rep;
            r_bid  <= i_set.bid;
        end
    end

endmodule

FILE: rtl/confusable_text_normalizer_core.sv
// Streaming text normalizer: one Unicode code point per input transaction.
// Input channel: i_in_valid / o_in_ready with i_code_point, i_has_char and
// i_end_of_text. Output channel: o_out_valid / i_out_ready with the result
// fields. Bidirectional controls are dropped and counted, modifier letters
// are mapped to ASCII and counted, whitespace runs collapse to one space,
// and an end-of-text transaction adds a summary with both counts.
// An accepted transaction waits in the input register until the result
// register can load, then its zero to three results are loaded into the
// result register, from which the first result is offered. The result
// register sends one result per cycle while the receiver is ready, and a
// transaction holds it until all its results are taken. Transactions with
// one result run at one per cycle while the receiver is ready. The next
// transaction is taken into the input register while earlier results still
// wait. When the receiver stalls, the results hold and the input register
// fills, after which o_in_ready drops.
// Reset clears the whitespace and emission flags, both counters and all
// pending results.
module confusable_text_normalizer_core
    import cfn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CP_BITS-1:0]    i_code_point,
    input  logic                  i_has_char,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_item_kind,
    output logic [CP_BITS-1:0]    o_out_char,
    output logic [TOTAL_BITS-1:0] o_replace_total,
    output logic [TOTAL_BITS-1:0] o_bidi_total,
    output logic                  o_last_of_run
);

    logic               r_in_valid;
    logic [CP_BITS-1:0] r_code_point;
    logic               r_has_char;
    logic               r_end_of_text;

    logic        can_load;
    logic        advance;
    logic        in_take;
    t_class      cls;
    t_result_set set;

    assign advance    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code_point  <= i_code_point;
            r_has_char    <= i_has_char;
            r_end_of_text <= i_end_of_text;
        end
    end

    cfn_classify u_classify (
        .i_code_point (r_code_point),
        .o_class      (cls)
    );

    cfn_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_class       (cls),
        .i_code_point  (r_code_point),
        .i_has_char    (r_has_char),
        .i_end_of_text (r_end_of_text),
        .o_set         (set)
    );

    cfn_out_buffer u_out_buffer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance),
        .i_set           (set),
        .o_can_load      (can_load),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_item_kind     (o_item_kind),
        .o_out_char      (o_out_char),
        .o_replace_total (o_replace_total),
        .o_bidi_total    (o_bidi_total),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

FILE: rtl/cfn_checker.sv
module cfn_checker
    import cfn_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [CP_BITS-1:0]    i_code_point,
    input logic                  i_has_char,
    input logic                  i_end_of_text,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_item_kind,
    input logic [CP_BITS-1:0]    o_out_char,
    input logic [TOTAL_BITS-1:0] o_replace_total,
    input logic [TOTAL_BITS-1:0] o_bidi_total,
    input logic                  o_last_of_run
);

    // A stalled result transaction stays offered with the same fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_item_kind) && $stable(o_out_char)
            && $stable(o_last_of_run))
        else $error("stalled result changed");

    // The summary is always the final result of its input transaction.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_item_kind == KIND_SUMMARY) |-> o_last_of_run)
        else $error("summary not marked last");

    // Character results carry no totals.
    a_char_no_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_item_kind == KIND_CHAR) |->
            (o_replace_total == '0) && (o_bidi_total == '0))
        else $error("character result carries totals");

    // A space on the output is always a collapsed run followed by a visible character.
    a_space_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_item_kind == KIND_CHAR) && (o_out_char == SPACE_CP)
            |-> !o_last_of_run)
        else $error("space emitted as final result");

endmodule

bind confusable_text_normalizer_core cfn_checker u_cfn_checker (.*);
